// File: sv/dfc_pkg.sv
// ----------------------------------------------------------------------------
// dfc_pkg - shared types and constants for the delimited field cutter
// Character codes, split modes, CSR indexes and the beat kind that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

   localparam int NUM_RANGES_DEFAULT = 4;
   localparam int INDEX_BITS_DEFAULT = 16;
   localparam int FIFO_DEPTH_DEFAULT = 2;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int RANGE_BITS     = 16;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_SPACE  = 2'd1;
   localparam logic [1:0] MODE_CSV    = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPLIT_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELIMITER  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SKIP_EN    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SKIP_BYTE  = 3'd3;
   localparam int                        CSR_RANGE_0    = 4;

   localparam logic [7:0] DELIMITER_RESET = CH_TAB;

   // What the front end decided about one accepted beat.
   typedef enum logic [1:0] {
      KIND_PASS,   // pass-through line byte, always emitted
      KIND_DATA,   // field content byte, emitted if field selected
      KIND_DELIM,  // field separator, may emit a tab
      KIND_EOL     // end of line, emits newline
   } kind_type;

   localparam int KIND_BITS = $bits(kind_type);

   typedef struct packed {
      logic [1:0] split_mode;
      logic [7:0] delimiter_char;
      logic       skip_enable;
      logic [7:0] skip_byte;
   } front_cfg_type;

endpackage

`default_nettype wire

// File: sv/dfc_fifo.sv
// ----------------------------------------------------------------------------
// dfc_fifo - short flop queue between front and back end
// Push and pop may happen in the same cycle; full and empty come from a
// registered count.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_fifo
   import dfc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_BITS = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/dfc_front.sv
// ----------------------------------------------------------------------------
// dfc_front - line parser
// Tracks line start, pass-through, CSV quoting and the field index, and
// tags each accepted beat with its kind and field index.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_front
   import dfc_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire front_cfg_type         cfg,
   input  wire logic                  accept,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  line_end,
   output kind_type                   tag_kind,
   output logic      [7:0]            tag_byte,
   output logic      [INDEX_BITS-1:0] tag_index
);

   logic [INDEX_BITS-1:0] field_index_ff, field_index_in;
   logic                  in_quotes_ff, in_quotes_in;
   logic                  escape_ff, escape_in;
   logic                  line_start_ff, line_start_in;
   logic                  pass_ff, pass_in;

   logic is_space;
   logic delim;

   assign is_space = ((in_byte >= CH_TAB) && (in_byte <= CH_CR)) || (in_byte == CH_SPACE);

   always_comb begin
      field_index_in = field_index_ff;
      in_quotes_in   = in_quotes_ff;
      escape_in      = escape_ff;
      line_start_in  = line_start_ff;
      pass_in        = pass_ff;
      delim          = 1'b0;
      tag_kind       = KIND_DATA;
      tag_byte       = in_byte;
      tag_index      = field_index_ff;

      if (line_end) begin
         field_index_in = '0;
         in_quotes_in   = 1'b0;
         escape_in      = 1'b0;
         line_start_in  = 1'b1;
         pass_in        = 1'b0;
         tag_kind       = KIND_EOL;
      end else begin
         line_start_in = 1'b0;
         pass_in = pass_ff ||
                   (line_start_ff && cfg.skip_enable && (in_byte == cfg.skip_byte));
         if (pass_in) begin
            tag_kind = KIND_PASS;
         end else begin
            case (cfg.split_mode)
               MODE_SINGLE: delim = (in_byte == cfg.delimiter_char);
               MODE_SPACE:  delim = is_space;
               MODE_CSV: begin
                  if (escape_ff) begin
                     escape_in = 1'b0;
                  end else if (!in_quotes_ff && (in_byte == CH_COMMA)) begin
                     delim = 1'b1;
                  end else if (in_quotes_ff && (in_byte == CH_BSLASH)) begin
                     escape_in = 1'b1;
                  end else if (in_byte == CH_QUOTE) begin
                     in_quotes_in = !in_quotes_ff;
                  end
               end
               default: delim = 1'b0;  // mode 3: whole line is one field
            endcase
            if (delim) begin
               if (field_index_ff != '1) begin
                  field_index_in = field_index_ff + 1'b1;
               end
               tag_kind  = KIND_DELIM;
               tag_index = field_index_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff <= '0;
         in_quotes_ff   <= 1'b0;
         escape_ff      <= 1'b0;
         line_start_ff  <= 1'b1;
         pass_ff        <= 1'b0;
      end else if (accept) begin
         field_index_ff <= field_index_in;
         in_quotes_ff   <= in_quotes_in;
         escape_ff      <= escape_in;
         line_start_ff  <= line_start_in;
         pass_ff        <= pass_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/dfc_back.sv
// ----------------------------------------------------------------------------
// dfc_back - field selector and output register
// Checks the field index against the ranges, tracks whether the line has
// output anything, and drives the rsp beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_back
   import dfc_pkg::*;
#(
   parameter int NUM_RANGES = NUM_RANGES_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [CSR_DATA_BITS-1:0] ranges [NUM_RANGES],
   input  wire logic                     entry_valid,
   input  wire kind_type                 entry_kind,
   input  wire logic [7:0]               entry_byte,
   input  wire logic [INDEX_BITS-1:0]    entry_index,
   output logic                          entry_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [7:0]               rsp_out_byte,
   output logic                          rsp_line_done
);

   localparam int CMP_BITS = (INDEX_BITS > RANGE_BITS) ? INDEX_BITS : RANGE_BITS;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       done_ff, done_in;
   logic       emitted_ff, emitted_in;
   logic       selected;
   logic       emit;
   logic [CMP_BITS-1:0] idx_ext;

   assign idx_ext = CMP_BITS'(entry_index);

   always_comb begin
      selected = 1'b0;
      for (int r = 0; r < NUM_RANGES; r++) begin
         if ((idx_ext >= CMP_BITS'(ranges[r][2*RANGE_BITS-1:RANGE_BITS])) &&
             (idx_ext <  CMP_BITS'(ranges[r][RANGE_BITS-1:0]))) begin
            selected = 1'b1;
         end
      end
   end

   assign entry_pop = entry_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      emit       = 1'b0;
      byte_in    = byte_ff;
      done_in    = done_ff;
      emitted_in = emitted_ff;
      case (entry_kind)
         KIND_PASS: begin
            emit    = 1'b1;
            byte_in = entry_byte;
            done_in = 1'b0;
         end
         KIND_DATA: begin
            emit    = selected;
            byte_in = entry_byte;
            done_in = 1'b0;
            if (entry_pop && selected) begin
               emitted_in = 1'b1;
            end
         end
         KIND_DELIM: begin
            emit    = emitted_ff && selected;
            byte_in = CH_TAB;
            done_in = 1'b0;
         end
         KIND_EOL: begin
            emit    = 1'b1;
            byte_in = CH_NL;
            done_in = 1'b1;
            if (entry_pop) begin
               emitted_in = 1'b0;
            end
         end
         default: emit = 1'b0;
      endcase

      if (entry_pop) begin
         valid_in = emit;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         emitted_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         emitted_ff <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop && emit) begin
         byte_ff <= byte_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_line_done = done_ff;

endmodule

`default_nettype wire

// File: sv/delimited_field_cut.sv
// ----------------------------------------------------------------------------
// delimited_field_cut - streaming column cutter for delimited text
// Splits text lines into fields and passes on the bytes of selected fields.
// ----------------------------------------------------------------------------
// Takes one text beat per clock on req while req_stall is low (a byte, or an
// end-of-line marker with req_line_end high) and gives at most one rsp beat for
// it, in order. Fields are split on a single delimiter byte, on any whitespace,
// or CSV-style on commas outside double quotes (backslash escapes inside
// quotes); only fields whose index falls in one of the begin/end ranges are
// output, with a tab before each selected field once the line has output
// anything and a newline (rsp_line_done high) ending every line. A line whose
// first byte matches the skip byte, when enabled, goes through as is. Sustained
// rate is one beat per clock while rsp is not stalled; a result passes through
// the queue and the rsp register before it shows on rsp. The front parser
// writes a small queue (FIFO_DEPTH entries) that the back end drains into the
// rsp register, so req_stall rises only when the queue is full, i.e. after rsp
// stalls. CSRs must be written only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_field_cut
   import dfc_pkg::*;
#(
   parameter int NUM_RANGES = NUM_RANGES_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // config writes
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data,
   // text in
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_in_byte,
   input  wire logic                      req_line_end,
   // text out
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [7:0]                rsp_out_byte,
   output logic                           rsp_line_done
);

   localparam int ENTRY_BITS = KIND_BITS + 8 + INDEX_BITS;

   // ---------------------------------------------------------------------
   // CSRs. Ranges at or above NUM_RANGES are not stored.
   // ---------------------------------------------------------------------
   front_cfg_type            cfg_ff;
   logic [CSR_DATA_BITS-1:0] range_ff [NUM_RANGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.split_mode     <= MODE_SINGLE;
         cfg_ff.delimiter_char <= DELIMITER_RESET;
         cfg_ff.skip_enable    <= 1'b0;
         cfg_ff.skip_byte      <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SPLIT_MODE: cfg_ff.split_mode     <= csr_write_data[1:0];
            CSR_DELIMITER:  cfg_ff.delimiter_char <= csr_write_data[7:0];
            CSR_SKIP_EN:    cfg_ff.skip_enable    <= csr_write_data[0];
            CSR_SKIP_BYTE:  cfg_ff.skip_byte      <= csr_write_data[7:0];
            default: ;  // range writes handled below
         endcase
      end
   end

   for (genvar r = 0; r < NUM_RANGES; r++) begin : g_range
      always_ff @(posedge clock) begin
         if (reset) begin
            range_ff[r] <= '0;
         end else if (csr_write_enable &&
                      (csr_index == CSR_INDEX_BITS'(CSR_RANGE_0 + r))) begin
            range_ff[r] <= csr_write_data;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Front: parse and tag each accepted beat, push it into the queue.
   // ---------------------------------------------------------------------
   logic                  req_accept;
   logic                  q_full;
   logic                  q_empty;
   logic                  q_pop;
   kind_type              tag_kind;
   logic [7:0]            tag_byte;
   logic [INDEX_BITS-1:0] tag_index;
   logic [ENTRY_BITS-1:0] q_head;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   dfc_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (req_accept),
      .in_byte   (req_in_byte),
      .line_end  (req_line_end),
      .tag_kind  (tag_kind),
      .tag_byte  (tag_byte),
      .tag_index (tag_index)
   );

   dfc_fifo #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data ({tag_kind, tag_byte, tag_index}),
      .pop       (q_pop),
      .pop_data  (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // ---------------------------------------------------------------------
   // Back: select fields and drive the rsp register.
   // ---------------------------------------------------------------------
   kind_type              head_kind;
   logic [7:0]            head_byte;
   logic [INDEX_BITS-1:0] head_index;

   assign head_kind  = kind_type'(q_head[ENTRY_BITS-1 -: KIND_BITS]);
   assign head_byte  = q_head[INDEX_BITS +: 8];
   assign head_index = q_head[INDEX_BITS-1:0];

   dfc_back #(
      .NUM_RANGES (NUM_RANGES),
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .ranges        (range_ff),
      .entry_valid   (!q_empty),
      .entry_kind    (head_kind),
      .entry_byte    (head_byte),
      .entry_index   (head_index),
      .entry_pop     (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_line_done (rsp_line_done)
   );

endmodule

`default_nettype wire

// File: sv/dfc_checker.sv
// ----------------------------------------------------------------------------
// dfc_checker - port-level checks for delimited_field_cut
// Watches the rsp channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_checker
   import dfc_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_line_done
);

   // stalled beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // stalled payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_byte) && $stable(rsp_line_done))
      else $error("rsp payload changed while stalled");

   // end of line always carries a newline
   a_eol_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_out_byte == CH_NL)
      else $error("line_done beat without newline");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind delimited_field_cut dfc_checker u_dfc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_line_done (rsp_line_done)
);

`default_nettype wire
